>>> hw/rtl/sif_pkg.sv
// ----------------------------------------------------------------------------
// sif_pkg
// Shared widths, codes and controller/datapath interface types for the set
// intersection filter.
// ----------------------------------------------------------------------------
package sif_pkg;

    localparam int DATA_W          = 32;
    localparam int OP_W            = 2;
    localparam int ST_W            = 3;
    localparam int MAX_ENTRIES_DEF = 256;

    // Operation codes carried on the input tuser.
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_PROBE = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // Result status codes carried on the output tuser.
    localparam logic [ST_W-1:0] ST_LOADED  = 3'd0;
    localparam logic [ST_W-1:0] ST_DROPPED = 3'd1;
    localparam logic [ST_W-1:0] ST_MATCH   = 3'd2;
    localparam logic [ST_W-1:0] ST_MISS    = 3'd3;
    localparam logic [ST_W-1:0] ST_CLEARED = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;     // take the input item this cycle
        logic rd_en;      // issue a store read at the scan index
        logic set_match;  // latch a match result
        logic set_miss;   // latch a miss result
        logic emit;       // move the pending result into the output register
    } sif_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_probe;   // input item is a probe
        logic in_void;    // input item has an unused op and gives no result
        logic can_read;   // scan index is below the loaded count
        logic hit;        // entry read last cycle equals the probe
        logic exhaust;    // all loaded entries read and compared
        logic out_free;   // output register can take a result this cycle
    } sif_sts_t;

endpackage

>>> hw/rtl/sif_ram.sv
// ----------------------------------------------------------------------------
// sif_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sif_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/sif_dp.sv
// ----------------------------------------------------------------------------
// sif_dp
// Datapath: element store, loaded count, scan index and compare, pending
// result and output register.
// ----------------------------------------------------------------------------
module sif_dp #(
    parameter int MAX_ENTRIES = sif_pkg::MAX_ENTRIES_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  sif_pkg::sif_cmd_t           cmd,
    output sif_pkg::sif_sts_t           sts,
    input  logic [sif_pkg::OP_W-1:0]    s_tuser,
    input  logic [sif_pkg::DATA_W-1:0]  s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [sif_pkg::ST_W-1:0]    m_tuser,
    output logic [sif_pkg::DATA_W-1:0]  m_tdata
);
    import sif_pkg::*;

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic              cmp_vld_reg;
    logic [DATA_W-1:0] probe_reg;
    logic [ST_W-1:0]   res_status_reg, res_status_next;
    logic [DATA_W-1:0] res_value_reg, res_value_next;
    logic              out_valid_reg;
    logic [ST_W-1:0]   out_status_reg;
    logic [DATA_W-1:0] out_value_reg;
    logic [DATA_W-1:0] rd_data;
    logic              full;
    logic              ram_we;

    assign full   = (count_reg == CW'(MAX_ENTRIES));
    assign ram_we = cmd.accept && (s_tuser == OP_LOAD) && !full;

    sif_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_ENTRIES),
        .AW    (AW)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (s_tdata),
        .re    (cmd.rd_en),
        .raddr (idx_reg[AW-1:0]),
        .rdata (rd_data)
    );

    always_comb begin
        count_next      = count_reg;
        idx_next        = idx_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        if (cmd.accept) begin
            idx_next       = '0;
            res_value_next = s_tdata;
            unique case (s_tuser)
                OP_LOAD: begin
                    if (full) begin
                        res_status_next = ST_DROPPED;
                    end else begin
                        res_status_next = ST_LOADED;
                        count_next      = count_reg + CW'(1);
                    end
                end
                OP_CLEAR: begin
                    res_status_next = ST_CLEARED;
                    res_value_next  = '0;
                    count_next      = '0;
                end
                default: begin
                    res_status_next = ST_MISS;
                end
            endcase
        end
        if (cmd.rd_en) begin
            idx_next = idx_reg + CW'(1);
        end
        if (cmd.set_match) begin
            res_status_next = ST_MATCH;
        end else if (cmd.set_miss) begin
            res_status_next = ST_MISS;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            idx_reg       <= '0;
            cmp_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            cmp_vld_reg <= cmd.rd_en;
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        if (cmd.accept) begin
            probe_reg <= s_tdata;
        end
        if (cmd.emit) begin
            out_status_reg <= res_status_reg;
            out_value_reg  <= res_value_reg;
        end
    end

    assign sts.in_probe = (s_tuser == OP_PROBE);
    assign sts.in_void  = (s_tuser != OP_LOAD) && (s_tuser != OP_PROBE)
                          && (s_tuser != OP_CLEAR);
    assign sts.can_read = (idx_reg < count_reg);
    assign sts.hit      = cmp_vld_reg && (rd_data == probe_reg);
    // Nothing left to read and the last read has already been compared.
    assign sts.exhaust  = !cmp_vld_reg && (idx_reg >= count_reg);
    assign sts.out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = out_value_reg;

endmodule

>>> hw/rtl/sif_ctrl.sv
// ----------------------------------------------------------------------------
// sif_ctrl
// Controller: accepts items, sequences the store scan of a probe and hands
// each result to the output register.
// ----------------------------------------------------------------------------
module sif_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  sif_pkg::sif_sts_t  sts,
    output sif_pkg::sif_cmd_t  cmd
);
    import sif_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                cmd.accept = s_tvalid;
                if (s_tvalid) begin
                    priority if (sts.in_void) begin
                        state_next = S_IDLE;
                    end else if (sts.in_probe) begin
                        state_next = S_SCAN;
                    end else begin
                        state_next = S_EMIT;
                    end
                end
            end
            S_SCAN: begin
                cmd.rd_en = sts.can_read && !sts.hit;
                if (sts.hit) begin
                    cmd.set_match = 1'b1;
                    state_next    = S_EMIT;
                end else if (sts.exhaust) begin
                    cmd.set_miss = 1'b1;
                    state_next   = S_EMIT;
                end
            end
            S_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

endmodule

>>> hw/rtl/set_intersection_filter.sv
// ----------------------------------------------------------------------------
// set_intersection_filter
// Streaming set intersection by linear search over a loaded element store.
// ----------------------------------------------------------------------------
// Load items (op 0) append a value to the store, probe items (op 1) search the
// loaded entries in order for an equal value, stopping at the first one, and
// clear items (op 2) empty the store; op 3 is ignored and gives no result.
// Every other item gives one result: the status on m_tuser and the value on
// m_tdata. The search reads the store through its single read port, one
// entry per cycle, and a miss is decided only after the last entry read has
// been compared. A result waiting in the output register holds the next
// result back until the receiver takes it, but does not stop the next item
// from being accepted.
module set_intersection_filter #(
    parameter int MAX_ENTRIES = sif_pkg::MAX_ENTRIES_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [sif_pkg::DATA_W-1:0]  s_tdata,   // [31:0] value
    input  logic [sif_pkg::OP_W-1:0]    s_tuser,   // [1:0] op
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [sif_pkg::DATA_W-1:0]  m_tdata,   // [31:0] value_out
    output logic [sif_pkg::ST_W-1:0]    m_tuser    // [2:0] status
);
    import sif_pkg::*;

    sif_cmd_t cmd;
    sif_sts_t sts;

    sif_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sif_dp #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata)
    );

    // A result is only moved forward when the output register can take it.
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> sts.out_free)
        else $error("result emitted while the output register was occupied");

    a_emit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> m_tvalid)
        else $error("emitted result not presented on the output");

    a_one_verdict: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.set_match && cmd.set_miss))
        else $error("probe marked as both match and miss");

    // A probe needs at least the scan and the result hand-off before the next item.
    a_probe_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == OP_PROBE) |=> !s_tready)
        else $error("new item accepted during a probe search");

endmodule
